// ----- sv/rip_pkg.sv -----
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants of the radix integer parser
// phase codes, character constants and the character-to-digit mapping
// ----------------------------------------------------------------------------
package rip_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned ValW   = 64;
  localparam int unsigned OutCntW = 11;

  // parser phases
  localparam logic [PhaseW-1:0] PH_SIGN        = 3'd0;
  localparam logic [PhaseW-1:0] PH_AUTO_ZERO   = 3'd1;
  localparam logic [PhaseW-1:0] PH_PREFIX_WAIT = 3'd2;
  localparam logic [PhaseW-1:0] PH_DIGITS      = 3'd3;
  localparam logic [PhaseW-1:0] PH_STOPPED     = 3'd4;

  localparam logic [7:0] NO_DIGIT = 8'd255;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_B  = 8'h62;

  localparam logic [BaseW-1:0] BASE_2  = 6'd2;
  localparam logic [BaseW-1:0] BASE_8  = 6'd8;
  localparam logic [BaseW-1:0] BASE_10 = 6'd10;
  localparam logic [BaseW-1:0] BASE_16 = 6'd16;
  localparam logic [BaseW-1:0] RADIX_AUTO = 6'd0;
  localparam logic [BaseW-1:0] RADIX_RESET = 6'd10;

  // per-string control state
  typedef struct packed {
    logic              minus;
    logic [PhaseW-1:0] phase;
    logic [BaseW-1:0]  base;
  } rip_ctl_t;

  localparam rip_ctl_t CTL_CLEAR = '{minus: 1'b0, phase: PH_SIGN, base: '0};

  // 0-9, A-Z, a-z map to 0..35, anything else to NO_DIGIT
  function automatic logic [7:0] digit_value(logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A + 8'd10;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + 8'd10;
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

endpackage

// ----- sv/rip_step.sv -----
// ----------------------------------------------------------------------------
// rip_step: one-character parser step
// next control state, accumulator and count for one buffered character
// ----------------------------------------------------------------------------
module rip_step import rip_pkg::*; #(
  parameter int unsigned MaxLen = 1024,
  parameter int unsigned CntW   = $clog2(MaxLen + 1)
) (
  input  logic [BaseW-1:0] radix_i,
  input  logic             has_char_i,
  input  logic [7:0]       ch_i,
  input  rip_ctl_t         ctl_i,
  input  logic [ValW-1:0]  accum_i,
  input  logic [CntW-1:0]  count_i,
  output rip_ctl_t         ctl_o,
  output logic [ValW-1:0]  accum_o,
  output logic [CntW-1:0]  count_o
);

  logic             inc;
  logic             do_digit;
  logic [BaseW-1:0] dig_base;
  logic [7:0]       dig;
  logic             dig_ok;
  logic             is_x;
  logic             is_b;
  logic [ValW-1:0]  mac;

  assign is_x   = (ch_i == CH_LO_X) || (ch_i == CH_UP_X);
  assign is_b   = (ch_i == CH_LO_B) || (ch_i == CH_UP_B);
  assign dig    = digit_value(ch_i);

  always_comb begin
    ctl_o    = ctl_i;
    accum_o  = accum_i;
    inc      = 1'b0;
    do_digit = 1'b0;
    dig_base = ctl_i.base;
    dig_ok   = 1'b0;
    mac      = '0;

    if (has_char_i) begin
      case (ctl_i.phase)
        PH_SIGN: begin
          if (ch_i == CH_MINUS) begin
            ctl_o.minus = ~ctl_i.minus;
            inc = 1'b1;
          end else if (ch_i == CH_PLUS) begin
            inc = 1'b1;
          end else if (radix_i == RADIX_AUTO) begin
            if (ch_i == CH_ZERO) begin
              inc = 1'b1;
              ctl_o.base  = BASE_8;
              ctl_o.phase = PH_AUTO_ZERO;
            end else begin
              ctl_o.base = BASE_10;
              dig_base   = BASE_10;
              do_digit   = 1'b1;
            end
          end else begin
            ctl_o.base = radix_i;
            dig_base   = radix_i;
            if ((radix_i == BASE_16 || radix_i == BASE_2) && ch_i == CH_ZERO) begin
              inc = 1'b1;
              ctl_o.phase = PH_PREFIX_WAIT;
            end else begin
              do_digit = 1'b1;
            end
          end
        end
        PH_AUTO_ZERO: begin
          if (is_x) begin
            ctl_o.base  = BASE_16;
            ctl_o.phase = PH_DIGITS;
            inc = 1'b1;
          end else if (is_b) begin
            ctl_o.base  = BASE_2;
            ctl_o.phase = PH_DIGITS;
            inc = 1'b1;
          end else begin
            ctl_o.base = BASE_8;
            dig_base   = BASE_8;
            do_digit   = 1'b1;
          end
        end
        PH_PREFIX_WAIT: begin
          if ((ctl_i.base == BASE_16 && is_x) || (ctl_i.base == BASE_2 && is_b)) begin
            ctl_o.phase = PH_DIGITS;
            inc = 1'b1;
          end else begin
            do_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
        end
      endcase

      if (do_digit) begin
        dig_ok = dig < {2'b00, dig_base};
        // single multiply-add per character
        mac    = ValW'(accum_i * ValW'(dig_base)) + ValW'(dig);
        if (dig_ok) begin
          accum_o     = mac;
          inc         = 1'b1;
          ctl_o.phase = PH_DIGITS;
        end else begin
          ctl_o.phase = PH_STOPPED;
        end
      end
    end
  end

  // saturating character count
  assign count_o = (inc && count_i < CntW'(MaxLen)) ? count_i + CntW'(1) : count_i;

endmodule

// ----- sv/radix_integer_parser_top.sv -----
// ----------------------------------------------------------------------------
// radix_integer_parser_top: streaming string-to-integer parser
// takes one character per item and gives value and consumed count per string
// ----------------------------------------------------------------------------
// The parser takes one character item per clock cycle while not stalled,
// with no bubbles between strings. Each accepted item is held in an input
// register; from there a single 64 x 6 multiply-add updates the running
// state, and for the item that carries tlast the result is loaded into the
// output register. The only stall is a last item meeting an output
// register whose previous result has not been taken yet; it waits in the
// input register and blocks new items until then. tuser set
// means tdata carries a character; tuser clear with tlast set ends a string
// with no character; an item with both clear does nothing. The radix register
// (0 = auto detect from a 0x / 0b / 0 prefix, 2..36 a fixed base) is sampled
// at the first non-sign character of a string and should be written only
// while idle. The consumed count saturates at MaxLen and leaves on its low
// 11 bits.
// ----------------------------------------------------------------------------
module radix_integer_parser_top import rip_pkg::*; #(
  parameter int unsigned MaxLen = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // radix register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  // character items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,    // [7:0] ch
  input  logic        s_axis_tuser_i,    // [0] has_char
  input  logic        s_axis_tlast_i,    // last character of the string
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o     // [63:0] value, [74:64] consumed, rest zero
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned ExtW = (CntW > OutCntW) ? CntW : OutCntW;

  // radix register
  logic [BaseW-1:0] radix_q;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_ch_q;
  logic             in_has_q;
  logic             in_last_q;

  // running string state
  rip_ctl_t         ctl_q, ctl_d, ctl_n;
  logic [ValW-1:0]  accum_q, accum_d, accum_n;
  logic [CntW-1:0]  count_q, count_d, count_n;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [ValW-1:0]  out_value_q;
  logic [OutCntW-1:0] out_cnt_q;

  logic             s_fire;
  logic             advance;
  logic             finish;
  logic [ExtW-1:0]  cnt_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_data_i;
    end
  end

  // the buffered item moves on unless it is a last item blocked by a full output
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign finish  = advance && in_last_q;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_ch_q   <= s_axis_tdata_i;
      in_has_q  <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  rip_step #(
    .MaxLen (MaxLen),
    .CntW   (CntW)
  ) u_step (
    .radix_i    (radix_q),
    .has_char_i (in_has_q),
    .ch_i       (in_ch_q),
    .ctl_i      (ctl_q),
    .accum_i    (accum_q),
    .count_i    (count_q),
    .ctl_o      (ctl_n),
    .accum_o    (accum_n),
    .count_o    (count_n)
  );

  // end of string clears the state for the next one
  always_comb begin
    ctl_d   = ctl_q;
    accum_d = accum_q;
    count_d = count_q;
    if (finish) begin
      ctl_d   = CTL_CLEAR;
      accum_d = '0;
      count_d = '0;
    end else if (advance) begin
      ctl_d   = ctl_n;
      accum_d = accum_n;
      count_d = count_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= CTL_CLEAR;
      accum_q <= '0;
      count_q <= '0;
    end else begin
      ctl_q   <= ctl_d;
      accum_q <= accum_d;
      count_q <= count_d;
    end
  end

  // result register
  assign out_valid_d = finish ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  assign cnt_ext     = ExtW'(count_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_value_q <= ctl_n.minus ? (ValW'(0) - accum_n) : accum_n;
      out_cnt_q   <= cnt_ext[OutCntW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_cnt_q, out_value_q};

  // a finished string always shows up in the result register next cycle
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("result not loaded after last item");

  // state is back at the start of a string after each result
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (count_q == '0 && accum_q == '0 && ctl_q.phase == PH_SIGN && !ctl_q.minus))
    else $error("string state not cleared after result");

  // count never passes its saturation limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxLen))
    else $error("character count above limit");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !finish)
    else $error("result overwritten while stalled");

endmodule
